/* hw/rtl/cfd_pkg.sv */
// Shared constants, types and operation codes of the complex decimating FIR core.
`timescale 1ns / 1ps
`default_nettype none

package cfd_pkg;

    localparam int COEF_BITS  = 32;
    localparam int COEF_IDX_W = 5;
    localparam int SAMPLE_W   = 32;
    localparam int ACC_BITS   = 64;
    localparam int SEEN_W     = 32;
    localparam int PHASE_W    = 6;

    localparam int TAPCNT_W   = 6;
    localparam int DECIM_W    = 7;
    localparam int CFG_DATA_W = 7;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECIM     = 1'd1;

    localparam logic [TAPCNT_W-1:0] TAP_COUNT_RST = 6'd32;
    localparam logic [DECIM_W-1:0]  DECIM_RST     = 7'd1;

    localparam int MAX_DECIM = 64;
    localparam int MAX_OUT   = 32;
    localparam int EMIT_W    = $clog2(MAX_OUT + 1);

    localparam int DEF_MAX_TAPS    = 32;
    localparam int DEF_SAMPLE_BITS = 32;

    localparam logic KIND_COEF   = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    typedef enum logic [1:0] {
        WIN_HOLD,
        WIN_SHIFT,
        WIN_ROT,
        WIN_CLEAR
    } t_win_op;

    typedef struct packed {
        t_win_op               win_op;
        logic                  tap_rot;
        logic                  tap_wr;
        logic [COEF_IDX_W-1:0] tap_idx;
    } t_cell_ctl;

endpackage

`default_nettype wire

/* hw/rtl/cfd_in_if.sv */
// Input channel carrying coefficient and sample words.
`timescale 1ns / 1ps
`default_nettype none

interface cfd_in_if import cfd_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic [COEF_IDX_W-1:0]        coef_index;
    logic signed [COEF_BITS-1:0]  coef_value;
    logic signed [SAMPLE_W-1:0]   sample_re;
    logic signed [SAMPLE_W-1:0]   sample_im;
    logic                         block_end;

    modport source (
        output valid, kind, coef_index, coef_value, sample_re, sample_im, block_end,
        input  ready
    );

    modport sink (
        input  valid, kind, coef_index, coef_value, sample_re, sample_im, block_end,
        output ready
    );
endinterface

`default_nettype wire

/* hw/rtl/cfd_out_if.sv */
// Output channel carrying filter result words.
`timescale 1ns / 1ps
`default_nettype none

interface cfd_out_if import cfd_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic signed [ACC_BITS-1:0]  out_re;
    logic signed [ACC_BITS-1:0]  out_im;
    logic                        final_result;

    modport source (
        output valid, out_re, out_im, final_result,
        input  ready
    );

    modport sink (
        input  valid, out_re, out_im, final_result,
        output ready
    );
endinterface

`default_nettype wire

/* hw/rtl/cfd_cell.sv */
// One cell of the window and tap chain: a complex sample and one coefficient.
`timescale 1ns / 1ps
`default_nettype none

module cfd_cell import cfd_pkg::*; #(
    parameter int CELL_INDEX  = 0,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire t_cell_ctl                     i_ctl,
    input  wire logic signed [SAMPLE_BITS-1:0] i_left_re,
    input  wire logic signed [SAMPLE_BITS-1:0] i_left_im,
    input  wire logic signed [SAMPLE_BITS-1:0] i_right_re,
    input  wire logic signed [SAMPLE_BITS-1:0] i_right_im,
    input  wire logic signed [COEF_BITS-1:0]   i_tap_left,
    input  wire logic signed [COEF_BITS-1:0]   i_coef,
    output logic signed [SAMPLE_BITS-1:0]      o_re,
    output logic signed [SAMPLE_BITS-1:0]      o_im,
    output logic signed [COEF_BITS-1:0]        o_tap
);

    localparam bit ADDRESSABLE = (CELL_INDEX < (1 << COEF_IDX_W));

    logic signed [SAMPLE_BITS-1:0] r_re;
    logic signed [SAMPLE_BITS-1:0] r_im;
    logic signed [COEF_BITS-1:0]   r_tap;
    logic signed [SAMPLE_BITS-1:0] n_re;
    logic signed [SAMPLE_BITS-1:0] n_im;
    logic signed [COEF_BITS-1:0]   n_tap;
    logic                          tap_hit;

    assign tap_hit = ADDRESSABLE && (i_ctl.tap_idx == COEF_IDX_W'(CELL_INDEX));

    always_comb begin
        unique case (i_ctl.win_op)
            WIN_HOLD: begin
                n_re = r_re;
                n_im = r_im;
            end
            WIN_SHIFT: begin
                n_re = i_left_re;
                n_im = i_left_im;
            end
            WIN_ROT: begin
                n_re = i_right_re;
                n_im = i_right_im;
            end
            WIN_CLEAR: begin
                n_re = '0;
                n_im = '0;
            end
        endcase
    end

    always_comb begin
        priority if (i_ctl.tap_wr && tap_hit) begin
            n_tap = i_coef;
        end else if (i_ctl.tap_rot) begin
            n_tap = i_tap_left;
        end else begin
            n_tap = r_tap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_re  <= '0;
            r_im  <= '0;
            r_tap <= '0;
        end else begin
            r_re  <= n_re;
            r_im  <= n_im;
            r_tap <= n_tap;
        end
    end

    assign o_re  = r_re;
    assign o_im  = r_im;
    assign o_tap = r_tap;

endmodule

`default_nettype wire

/* hw/rtl/cfd_mac.sv */
// Shared multiply-accumulate unit fed with the sample of cell 0 and the tap of the last cell.
`timescale 1ns / 1ps
`default_nettype none

module cfd_mac import cfd_pkg::*; #(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_clear,
    input  wire logic                          i_en,
    input  wire logic signed [SAMPLE_BITS-1:0] i_re,
    input  wire logic signed [SAMPLE_BITS-1:0] i_im,
    input  wire logic signed [COEF_BITS-1:0]   i_coef,
    output logic [ACC_BITS-1:0]                o_acc_re,
    output logic [ACC_BITS-1:0]                o_acc_im,
    output logic                               o_busy
);

    localparam int PROD_W = SAMPLE_BITS + COEF_BITS;

    logic                     r_prod_valid;
    logic signed [PROD_W-1:0] r_prod_re;
    logic signed [PROD_W-1:0] r_prod_im;
    logic signed [PROD_W-1:0] n_prod_re;
    logic signed [PROD_W-1:0] n_prod_im;
    logic [ACC_BITS-1:0]      r_acc_re;
    logic [ACC_BITS-1:0]      r_acc_im;

    assign n_prod_re = i_re * i_coef;
    assign n_prod_im = i_im * i_coef;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_valid <= 1'b0;
        end else begin
            r_prod_valid <= i_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod_re <= n_prod_re;
        r_prod_im <= n_prod_im;
        if (i_clear) begin
            r_acc_re <= '0;
            r_acc_im <= '0;
        end else if (r_prod_valid) begin
            r_acc_re <= r_acc_re + ACC_BITS'(r_prod_re);
            r_acc_im <= r_acc_im + ACC_BITS'(r_prod_im);
        end
    end

    assign o_acc_re = r_acc_re;
    assign o_acc_im = r_acc_im;
    assign o_busy   = r_prod_valid;

endmodule

`default_nettype wire

/* hw/rtl/complex_decimating_fir_core.sv */
// Top level of the complex decimating FIR core: sequencer, cell chain and output register.
//
// Usage: words enter on i_in_ch. A word of kind coefficient writes one tap while
// the core stays idle. A word of kind sample shifts one complex sample into the
// window chain. Results leave on o_out_ch through a one-deep output register,
// so the core accepts new words while a result waits to be taken.
// A sample that completes no window is shifted in and the core returns to idle.
// A sample that completes a window then rotates the taps into line, steps the
// effective taps through the single multiply-accumulate unit, which sees one
// tap per cycle while the window and tap chains rotate past it, rotates the
// window back into place and emits. A result is delivered when the next result
// of the block is computed, or at the end of the block, where it carries
// final_result. A block_end sample may be followed by a flush of zero samples.
// Reset is synchronous and active low: it clears taps, window, counters and
// the output register, and sets tap_count to 32 and decimation_factor to 1.
// If the receiver stalls, the core holds its next result until the output
// register is free, and input ready stays low until the current word is done.
`timescale 1ns / 1ps
`default_nettype none

module complex_decimating_fir_core import cfd_pkg::*; #(
    parameter int MAX_TAPS    = DEF_MAX_TAPS,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    cfd_in_if.sink                     i_in_ch,
    cfd_out_if.source                  o_out_ch
);

    localparam int CW    = $clog2(MAX_TAPS + 1);
    localparam int TW1   = TAPCNT_W + 1;
    localparam int GUARD = MAX_TAPS + MAX_DECIM + 1;
    localparam int GW    = $clog2(GUARD + 1);
    localparam int NEED_W = SEEN_W + 1 + DECIM_W;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PUSH  = 4'd1;
    localparam logic [3:0] S_ALIGN = 4'd2;
    localparam logic [3:0] S_MAC   = 4'd3;
    localparam logic [3:0] S_REST  = 4'd4;
    localparam logic [3:0] S_EMIT  = 4'd5;
    localparam logic [3:0] S_NEXT  = 4'd6;
    localparam logic [3:0] S_FINAL = 4'd7;
    localparam logic [3:0] S_CLEAR = 4'd8;

    logic [3:0]                    r_state,      n_state;
    logic [CW-1:0]                 r_cnt,        n_cnt;
    logic [TAPCNT_W-1:0]           r_tap_count;
    logic [DECIM_W-1:0]            r_decim;
    logic signed [SAMPLE_BITS-1:0] r_push_re,    n_push_re;
    logic signed [SAMPLE_BITS-1:0] r_push_im,    n_push_im;
    logic                          r_last,       n_last;
    logic                          r_flush,      n_flush;
    logic [SEEN_W-1:0]             r_real_n,     n_real_n;
    logic [GW-1:0]                 r_guard,      n_guard;
    logic [SEEN_W-1:0]             r_seen,       n_seen;
    logic [PHASE_W-1:0]            r_phase,      n_phase;
    logic [SEEN_W-1:0]             r_made,       n_made;
    logic                          r_held_valid, n_held_valid;
    logic [ACC_BITS-1:0]           r_held_re,    n_held_re;
    logic [ACC_BITS-1:0]           r_held_im,    n_held_im;
    logic [EMIT_W-1:0]             r_emit_cnt,   n_emit_cnt;
    logic                          r_out_valid;
    logic [ACC_BITS-1:0]           r_out_re;
    logic [ACC_BITS-1:0]           r_out_im;
    logic                          r_out_final;

    logic [CW-1:0]        eff_taps;
    logic [CW-1:0]        align_len;
    logic [DECIM_W-1:0]   eff_decim;
    logic [SEEN_W-1:0]    seen_inc;
    logic [SEEN_W-1:0]    made_inc;
    logic [DECIM_W-1:0]   phase_inc;
    logic [SEEN_W:0]      made_p1;
    logic [NEED_W-1:0]    need_n;
    logic                 in_acc;
    logic                 out_free;
    logic                 out_load;
    logic                 out_fin;
    logic                 emit_ok;
    logic                 mac_clear;
    logic                 mac_en;
    logic                 mac_busy;
    logic [ACC_BITS-1:0]  acc_re;
    logic [ACC_BITS-1:0]  acc_im;
    t_cell_ctl            cell_ctl;

    logic signed [SAMPLE_BITS-1:0] w_re [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0] w_im [MAX_TAPS];
    logic signed [COEF_BITS-1:0]   w_tap [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0] left_re [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0] left_im [MAX_TAPS];

    // Effective register values.
    always_comb begin
        if (r_tap_count == '0) begin
            eff_taps = CW'(1);
        end else if (TW1'(r_tap_count) > TW1'(MAX_TAPS)) begin
            eff_taps = CW'(MAX_TAPS);
        end else begin
            eff_taps = CW'(r_tap_count);
        end
        if (r_decim == '0) begin
            eff_decim = DECIM_W'(1);
        end else if (r_decim > DECIM_W'(MAX_DECIM)) begin
            eff_decim = DECIM_W'(MAX_DECIM);
        end else begin
            eff_decim = r_decim;
        end
    end

    assign align_len = CW'(MAX_TAPS) - eff_taps;
    assign seen_inc  = (r_seen == '1) ? r_seen : r_seen + SEEN_W'(1);
    assign made_inc  = (r_made == '1) ? r_made : r_made + SEEN_W'(1);
    assign phase_inc = DECIM_W'(r_phase) + DECIM_W'(1);
    assign made_p1   = (SEEN_W + 1)'(r_made) + (SEEN_W + 1)'(1);
    assign need_n    = NEED_W'(made_p1) * NEED_W'(eff_decim);

    assign in_acc   = i_in_ch.valid && i_in_ch.ready;
    assign out_free = !r_out_valid || o_out_ch.ready;
    assign emit_ok  = r_held_valid && (r_emit_cnt < EMIT_W'(MAX_OUT));

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count <= TAP_COUNT_RST;
            r_decim     <= DECIM_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TAP_COUNT: r_tap_count <= i_cfg_data[TAPCNT_W-1:0];
                CFG_DECIM:     r_decim     <= i_cfg_data[DECIM_W-1:0];
            endcase
        end
    end

    // Sequencer.
    always_comb begin
        logic do_mac;

        do_mac       = 1'b0;
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_push_re    = r_push_re;
        n_push_im    = r_push_im;
        n_last       = r_last;
        n_flush      = r_flush;
        n_real_n     = r_real_n;
        n_guard      = r_guard;
        n_seen       = r_seen;
        n_phase      = r_phase;
        n_made       = r_made;
        n_held_valid = r_held_valid;
        n_held_re    = r_held_re;
        n_held_im    = r_held_im;
        n_emit_cnt   = r_emit_cnt;
        out_load     = 1'b0;
        out_fin      = 1'b0;
        mac_clear    = 1'b0;
        mac_en       = 1'b0;
        cell_ctl.win_op  = WIN_HOLD;
        cell_ctl.tap_rot = 1'b0;
        cell_ctl.tap_wr  = 1'b0;
        cell_ctl.tap_idx = i_in_ch.coef_index;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_emit_cnt = '0;
                    if (i_in_ch.kind == KIND_COEF) begin
                        cell_ctl.tap_wr = 1'b1;
                    end else begin
                        n_push_re = i_in_ch.sample_re[SAMPLE_BITS-1:0];
                        n_push_im = i_in_ch.sample_im[SAMPLE_BITS-1:0];
                        n_last    = i_in_ch.block_end;
                        n_flush   = 1'b0;
                        n_state   = S_PUSH;
                    end
                end
            end
            S_PUSH: begin
                cell_ctl.win_op = WIN_SHIFT;
                n_seen = seen_inc;
                if (seen_inc < SEEN_W'(eff_taps)) begin
                    n_state = S_NEXT;
                end else if (seen_inc == SEEN_W'(eff_taps)) begin
                    n_phase = '0;
                    do_mac  = 1'b1;
                end else if (phase_inc >= eff_decim) begin
                    n_phase = '0;
                    do_mac  = 1'b1;
                end else begin
                    n_phase = phase_inc[PHASE_W-1:0];
                    n_state = S_NEXT;
                end
                if (do_mac) begin
                    mac_clear = 1'b1;
                    n_cnt     = '0;
                    n_state   = (align_len != '0) ? S_ALIGN : S_MAC;
                end
            end
            S_ALIGN: begin
                cell_ctl.tap_rot = 1'b1;
                if (r_cnt == align_len - CW'(1)) begin
                    n_cnt   = '0;
                    n_state = S_MAC;
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end
            S_MAC: begin
                cell_ctl.tap_rot = 1'b1;
                cell_ctl.win_op  = WIN_ROT;
                mac_en           = 1'b1;
                if (r_cnt == eff_taps - CW'(1)) begin
                    n_cnt   = '0;
                    n_state = (align_len != '0) ? S_REST : S_EMIT;
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end
            S_REST: begin
                cell_ctl.win_op = WIN_ROT;
                if (r_cnt == align_len - CW'(1)) begin
                    n_cnt   = '0;
                    n_state = S_EMIT;
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end
            S_EMIT: begin
                if (!mac_busy && (!emit_ok || out_free)) begin
                    if (emit_ok) begin
                        out_load   = 1'b1;
                        n_emit_cnt = r_emit_cnt + EMIT_W'(1);
                    end
                    n_held_re    = acc_re;
                    n_held_im    = acc_im;
                    n_held_valid = 1'b1;
                    n_made       = made_inc;
                    n_state      = S_NEXT;
                end
            end
            S_NEXT: begin
                if (!r_last) begin
                    n_state = S_IDLE;
                end else if (!r_flush) begin
                    if (r_seen >= SEEN_W'(eff_decim)) begin
                        n_flush  = 1'b1;
                        n_real_n = r_seen;
                        n_guard  = '0;
                    end else begin
                        n_state = S_CLEAR;
                    end
                end else if ((need_n <= NEED_W'(r_real_n)) && (r_guard < GW'(GUARD))) begin
                    n_guard   = r_guard + GW'(1);
                    n_push_re = '0;
                    n_push_im = '0;
                    n_state   = S_PUSH;
                end else begin
                    n_state = S_FINAL;
                end
            end
            S_FINAL: begin
                if (!emit_ok || out_free) begin
                    if (emit_ok) begin
                        out_load   = 1'b1;
                        out_fin    = 1'b1;
                        n_emit_cnt = r_emit_cnt + EMIT_W'(1);
                    end
                    n_state = S_CLEAR;
                end
            end
            S_CLEAR: begin
                cell_ctl.win_op = WIN_CLEAR;
                n_seen       = '0;
                n_phase      = '0;
                n_made       = '0;
                n_held_valid = 1'b0;
                n_flush      = 1'b0;
                n_last       = 1'b0;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cnt        <= '0;
            r_last       <= 1'b0;
            r_flush      <= 1'b0;
            r_guard      <= '0;
            r_seen       <= '0;
            r_phase      <= '0;
            r_made       <= '0;
            r_held_valid <= 1'b0;
            r_emit_cnt   <= '0;
        end else begin
            r_state      <= n_state;
            r_cnt        <= n_cnt;
            r_last       <= n_last;
            r_flush      <= n_flush;
            r_guard      <= n_guard;
            r_seen       <= n_seen;
            r_phase      <= n_phase;
            r_made       <= n_made;
            r_held_valid <= n_held_valid;
            r_emit_cnt   <= n_emit_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_push_re <= n_push_re;
        r_push_im <= n_push_im;
        r_real_n  <= n_real_n;
        r_held_re <= n_held_re;
        r_held_im <= n_held_im;
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_re    <= r_held_re;
            r_out_im    <= r_held_im;
            r_out_final <= out_fin;
        end
    end

    assign i_in_ch.ready         = (r_state == S_IDLE);
    assign o_out_ch.valid        = r_out_valid;
    assign o_out_ch.out_re       = r_out_re;
    assign o_out_ch.out_im       = r_out_im;
    assign o_out_ch.final_result = r_out_final;

    // Cell chain: the window shifts away from cell 0 and rotates toward it, taps rotate away from it.
    for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
        localparam int PREV = (k == 0) ? MAX_TAPS - 1 : k - 1;
        localparam int SUCC = (k == MAX_TAPS - 1) ? 0 : k + 1;

        if (k == 0) begin : g_head
            assign left_re[k] = r_push_re;
            assign left_im[k] = r_push_im;
        end else begin : g_body
            assign left_re[k] = w_re[PREV];
            assign left_im[k] = w_im[PREV];
        end

        cfd_cell #(
            .CELL_INDEX  (k),
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (cell_ctl),
            .i_left_re  (left_re[k]),
            .i_left_im  (left_im[k]),
            .i_right_re (w_re[SUCC]),
            .i_right_im (w_im[SUCC]),
            .i_tap_left (w_tap[PREV]),
            .i_coef     (i_in_ch.coef_value),
            .o_re       (w_re[k]),
            .o_im       (w_im[k]),
            .o_tap      (w_tap[k])
        );
    end

    cfd_mac #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (mac_clear),
        .i_en     (mac_en),
        .i_re     (w_re[0]),
        .i_im     (w_im[0]),
        .i_coef   (w_tap[MAX_TAPS-1]),
        .o_acc_re (acc_re),
        .o_acc_im (acc_im),
        .o_busy   (mac_busy)
    );

    a_emit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_emit_cnt <= EMIT_W'(MAX_OUT))
        else $error("More result words than allowed for one input word.");

    a_flush_in_block_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flush |-> r_last)
        else $error("Flush active without a block end.");

    a_mac_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NEXT) |-> !mac_busy)
        else $error("Accumulator still busy after the result was taken.");

    a_guard_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_guard <= GW'(GUARD))
        else $error("Flush ran past its bound.");

    a_mac_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAC) |=> mac_busy)
        else $error("Product stage did not follow a multiply step.");

endmodule

`default_nettype wire

/* verif/tb_complex_decimating_fir_core.sv */
// Self-checking testbench for complex_decimating_fir_core, run against a cycle-free predictor.
`timescale 1ns / 1ps

module tb_complex_decimating_fir_core;
    import cfd_pkg::*;

    localparam int NTAPS          = DEF_MAX_TAPS;
    localparam int SETTLE_CYCLES  = 200;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int WORDS_PER_CFG  = 45;

    typedef struct {
        logic                        kind;
        logic [COEF_IDX_W-1:0]       idx;
        logic signed [COEF_BITS-1:0] coef;
        logic signed [SAMPLE_W-1:0]  re;
        logic signed [SAMPLE_W-1:0]  im;
        logic                        last;
    } fir_word_t;

    typedef struct {
        logic signed [ACC_BITS-1:0] re;
        logic signed [ACC_BITS-1:0] im;
        logic                       fin;
    } fir_result_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    cfd_in_if  in_ch ();
    cfd_out_if out_ch ();

    complex_decimating_fir_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in_ch    (in_ch),
        .o_out_ch   (out_ch)
    );

    fir_result_t pending_results[$];
    int          fail_count   = 0;
    int          quiet_cycles = 0;
    int          src_idle_pct = 0;
    int          snk_stall_pct = 0;

    longint      coef_tab[NTAPS];
    longint      win_re[NTAPS];
    longint      win_im[NTAPS];
    int unsigned seen_cnt;
    int unsigned phase_cnt;
    int unsigned made_cnt;
    bit          held_v;
    longint      held_re;
    longint      held_im;
    int          step_results;
    logic [TAPCNT_W-1:0] cur_taps;
    logic [DECIM_W-1:0]  cur_decim;

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    function automatic int unsigned eff_taps();
        int unsigned t;
        t = cur_taps;
        if (t < 1) t = 1;
        if (t > NTAPS) t = NTAPS;
        return t;
    endfunction

    function automatic int unsigned eff_decim();
        int unsigned d;
        d = cur_decim;
        if (d < 1) d = 1;
        if (d > MAX_DECIM) d = MAX_DECIM;
        return d;
    endfunction

    function automatic void emit_result(longint re, longint im, bit fin);
        fir_result_t r;
        if (step_results < MAX_OUT) begin
            r.re  = re;
            r.im  = im;
            r.fin = fin;
            pending_results.push_back(r);
            step_results++;
        end
    endfunction

    function automatic void window_complete(int unsigned taps);
        longint acc_re;
        longint acc_im;
        acc_re = 0;
        acc_im = 0;
        for (int j = 0; j < taps; j++) begin
            acc_re += win_re[taps - 1 - j] * coef_tab[j];
            acc_im += win_im[taps - 1 - j] * coef_tab[j];
        end
        if (held_v) emit_result(held_re, held_im, 1'b0);
        held_re = acc_re;
        held_im = acc_im;
        held_v  = 1'b1;
        if (made_cnt != 32'hFFFF_FFFF) made_cnt++;
    endfunction

    function automatic void shift_sample(longint re, longint im);
        int unsigned taps;
        int unsigned dec;
        taps = eff_taps();
        dec  = eff_decim();
        for (int k = NTAPS - 1; k > 0; k--) begin
            win_re[k] = win_re[k - 1];
            win_im[k] = win_im[k - 1];
        end
        win_re[0] = re;
        win_im[0] = im;
        if (seen_cnt != 32'hFFFF_FFFF) seen_cnt++;
        if (seen_cnt < taps) return;
        if (seen_cnt == taps) begin
            phase_cnt = 0;
            window_complete(taps);
        end else begin
            phase_cnt++;
            if (phase_cnt >= dec) begin
                phase_cnt = 0;
                window_complete(taps);
            end
        end
    endfunction

    function automatic void clear_block();
        for (int k = 0; k < NTAPS; k++) begin
            win_re[k] = 0;
            win_im[k] = 0;
        end
        seen_cnt  = 0;
        phase_cnt = 0;
        made_cnt  = 0;
        held_v    = 1'b0;
        held_re   = 0;
        held_im   = 0;
    endfunction

    // Works out every result that one accepted word causes, in order.
    function automatic void predict_word(fir_word_t w);
        int unsigned real_n;
        int unsigned dec;
        int unsigned target;
        int unsigned guard;
        step_results = 0;
        if (w.kind == KIND_COEF) begin
            coef_tab[w.idx] = longint'(w.coef);
            return;
        end
        shift_sample(longint'(w.re), longint'(w.im));
        if (w.last) begin
            real_n = seen_cnt;
            dec    = eff_decim();
            if (real_n >= dec) begin
                target = real_n / dec;
                guard  = 0;
                while (made_cnt < target && guard < NTAPS + MAX_DECIM + 1) begin
                    shift_sample(0, 0);
                    guard++;
                end
                if (held_v) emit_result(held_re, held_im, 1'b1);
            end
            clear_block();
        end
    endfunction

    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        fir_result_t want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_results.size() == 0) begin
                $error("result word with no expectation: re %0d im %0d final %0b",
                       out_ch.out_re, out_ch.out_im, out_ch.final_result);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (out_ch.out_re !== want.re) begin
                    $error("out_re: expected %0d, got %0d", want.re, out_ch.out_re);
                    fail_count++;
                end
                if (out_ch.out_im !== want.im) begin
                    $error("out_im: expected %0d, got %0d", want.im, out_ch.out_im);
                    fail_count++;
                end
                if (out_ch.final_result !== want.fin) begin
                    $error("final_result: expected %0b, got %0b", want.fin,
                           out_ch.final_result);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("[complex_decimating_fir_core] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_word(input fir_word_t w);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.kind       <= w.kind;
        in_ch.coef_index <= w.idx;
        in_ch.coef_value <= w.coef;
        in_ch.sample_re  <= w.re;
        in_ch.sample_im  <= w.im;
        in_ch.block_end  <= w.last;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_word(w);
    endtask

    task automatic send_coef(input int idx, input logic [31:0] val, input bit last);
        fir_word_t w;
        w.kind = KIND_COEF;
        w.idx  = idx[COEF_IDX_W-1:0];
        w.coef = val;
        w.re   = $urandom;
        w.im   = $urandom;
        w.last = last;
        send_word(w);
    endtask

    task automatic send_sample(input logic [31:0] re, input logic [31:0] im, input bit last);
        fir_word_t w;
        w.kind = KIND_SAMPLE;
        w.idx  = $urandom;
        w.coef = $urandom;
        w.re   = re;
        w.im   = im;
        w.last = last;
        send_word(w);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data[CFG_DATA_W-1:0];
        @(negedge i_clk);
        cfg_we   <= 1'b0;
        if (idx == CFG_TAP_COUNT) cur_taps = data[TAPCNT_W-1:0];
        else cur_decim = data[DECIM_W-1:0];
    endtask

    task automatic set_filter(input int taps, input int decim);
        wait_idle();
        write_reg(CFG_TAP_COUNT, taps);
        write_reg(CFG_DECIM, decim);
    endtask

    function automatic logic [31:0] rand_value();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 5) return 32'h7FFF_FFFF;
        if (roll < 10) return 32'h8000_0000;
        if (roll < 14) return 32'h0;
        if (roll < 18) return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    function automatic int pick_taps();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 10) return 0;
        if (roll < 20) return 63;
        if (roll < 30) return 32;
        if (roll < 40) return 1;
        return $urandom_range(2, 32);
    endfunction

    function automatic int pick_decim();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 8) return 0;
        if (roll < 14) return 127;
        if (roll < 20) return 64;
        if (roll < 40) return 1;
        if (roll < 50) return $urandom_range(9, 64);
        return $urandom_range(2, 8);
    endfunction

    task automatic test_taps_and_extremes();
        set_filter(3, 1);
        send_coef(0, 32'h7FFF_FFFF, 1'b0);
        send_coef(1, 32'h8000_0000, 1'b0);
        send_coef(2, 32'hFFFF_FFFF, 1'b0);
        // A coefficient word ignores its block end flag.
        send_coef(31, 32'h8000_0000, 1'b1);
        send_sample(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        send_sample(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        send_sample(32'hFFFF_FFFF, 32'h0, 1'b0);
        send_sample(32'h0, 32'hFFFF_FFFF, 1'b1);
    endtask

    task automatic test_short_block();
        set_filter(2, 8);
        send_sample(rand_value(), rand_value(), 1'b0);
        send_sample(rand_value(), rand_value(), 1'b0);
        send_sample(rand_value(), rand_value(), 1'b1);
    endtask

    task automatic test_midblock_change();
        set_filter(3, 2);
        repeat (3) send_sample(rand_value(), rand_value(), 1'b0);
        set_filter(5, 3);
        send_sample(rand_value(), rand_value(), 1'b0);
        send_sample(rand_value(), rand_value(), 1'b0);
        send_sample(rand_value(), rand_value(), 1'b1);
    endtask

    task automatic test_register_limits();
        set_filter(0, 0);
        send_sample(rand_value(), rand_value(), 1'b0);
        send_sample(rand_value(), rand_value(), 1'b1);
        set_filter(63, 127);
        send_sample(rand_value(), rand_value(), 1'b0);
        send_sample(rand_value(), rand_value(), 1'b1);
    endtask

    task automatic test_random_blocks(input int idle_pct, input int stall_pct,
                                      input int words, input int first_taps,
                                      input int first_decim);
        int sent;
        int next_cfg;
        int len;
        int max_len;
        bit broken;
        sent     = 0;
        next_cfg = WORDS_PER_CFG;
        src_idle_pct  = idle_pct;
        snk_stall_pct = stall_pct;
        set_filter(first_taps, first_decim);
        while (sent < words) begin
            if (sent >= next_cfg) begin
                set_filter(pick_taps(), pick_decim());
                next_cfg += WORDS_PER_CFG;
            end
            if ($urandom_range(99) < 12) begin
                len = $urandom_range(1, 6);
                repeat (len) send_coef($urandom_range(31), rand_value(), $urandom_range(1));
                sent += len;
            end else begin
                max_len = eff_taps() + 2 * eff_decim();
                if (max_len > 100) max_len = 100;
                if ($urandom_range(99) < 15) len = eff_taps() + eff_decim() + $urandom_range(4);
                else len = $urandom_range(1, max_len);
                broken = ($urandom_range(99) < 10);
                for (int i = 0; i < len; i++) begin
                    if ($urandom_range(99) < 6) begin
                        send_coef($urandom_range(31), rand_value(), $urandom_range(1));
                        sent++;
                    end
                    send_sample(rand_value(), rand_value(), (i == len - 1) && !broken);
                    sent++;
                end
            end
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        cfg_we      = 1'b0;
        cfg_idx     = CFG_TAP_COUNT;
        cfg_data    = '0;
        in_ch.valid = 1'b0;
        in_ch.kind  = KIND_COEF;
        in_ch.coef_index = '0;
        in_ch.coef_value = '0;
        in_ch.sample_re  = '0;
        in_ch.sample_im  = '0;
        in_ch.block_end  = 1'b0;
        for (int k = 0; k < NTAPS; k++) coef_tab[k] = 0;
        clear_block();
        cur_taps  = TAP_COUNT_RST;
        cur_decim = DECIM_RST;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_taps_and_extremes();
        test_short_block();
        test_midblock_change();
        test_register_limits();
        test_random_blocks(0, 0, 92, 32, 1);
        test_random_blocks(74, 0, 92, pick_taps(), pick_decim());
        test_random_blocks(0, 74, 92, pick_taps(), pick_decim());
        test_random_blocks(29, 29, 92, pick_taps(), pick_decim());

        wait_idle();
        if (fail_count == 0) begin
            $display("[complex_decimating_fir_core] OK");
        end else begin
            $display("[complex_decimating_fir_core] ERROR");
        end
        $finish;
    end

endmodule
